>>> rtl/sine_cosine_taylor_assert.svh
// assertion macros for the sine and cosine unit
`ifndef SINE_COSINE_TAYLOR_ASSERT_SVH
`define SINE_COSINE_TAYLOR_ASSERT_SVH

// implication checked at every clock edge outside reset
`define SCT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sine_cosine_taylor implication failed");

// condition that must never hold outside reset
`define SCT_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("sine_cosine_taylor forbidden condition seen");

`endif

>>> rtl/sct_pkg.sv
// shared widths, constants and coefficient table for the sine and cosine unit
package sct_pkg;

   localparam int VAL_W      = 48;
   localparam int HALF_W     = VAL_W / 2;
   localparam int FRAC_BITS  = 40;
   localparam int ANGLE_W    = 32;
   localparam int RES_W      = 32;
   localparam int IN_SHIFT   = 12;
   localparam int OUT_SHIFT  = FRAC_BITS - 30;
   localparam int MAX_TERMS  = 10;
   localparam int DEF_TERMS  = 10;

   localparam logic signed [VAL_W-1:0] PI_Q40     = 48'sh03243F6A8886;
   localparam logic signed [VAL_W-1:0] TWO_PI_Q40 = 48'sh06487ED5110B;
   localparam logic [VAL_W-OUT_SHIFT-1:0] ONE_Q30 = (VAL_W-OUT_SHIFT)'(64'd1 << 30);

   typedef logic signed [VAL_W-1:0] val_type;

   // 1/n! in Q40 rounded to nearest, sign alternating with k
   function automatic val_type coeff_q40(input int n, input int k);
      val_type mag;
      unique case (n)
         0:       mag = 48'sd1099511627776;
         1:       mag = 48'sd1099511627776;
         2:       mag = 48'sd549755813888;
         3:       mag = 48'sd183251937963;
         4:       mag = 48'sd45812984491;
         5:       mag = 48'sd9162596898;
         6:       mag = 48'sd1527099483;
         7:       mag = 48'sd218157069;
         8:       mag = 48'sd27269634;
         9:       mag = 48'sd3029959;
         10:      mag = 48'sd302996;
         11:      mag = 48'sd27545;
         12:      mag = 48'sd2295;
         13:      mag = 48'sd177;
         14:      mag = 48'sd13;
         15:      mag = 48'sd1;
         default: mag = '0;
      endcase
      return (k % 2 == 1) ? -mag : mag;
   endfunction

endpackage

>>> rtl/sct_mul.sv
// three stage signed q40 multiply with addend: p = c + trunc(a * b >> 40)
module sct_mul
   import sct_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  val_type a,
   input  val_type b,
   input  val_type c,
   output logic    out_valid,
   output val_type p
);

   logic                 v1_ff, v2_ff, v3_ff;
   logic                 neg1_ff, neg2_ff;
   logic [VAL_W-1:0]     am1_ff, bm1_ff;
   val_type              c1_ff, c2_ff, p3_ff;
   logic [VAL_W-1:0]     ll2_ff, lh2_ff, hl2_ff, hh2_ff;
   logic [VAL_W-1:0]     am1_in, bm1_in;
   logic [2*VAL_W-1:0]   sum3;
   logic [VAL_W-1:0]     mag3;
   val_type              p3_in;

   // stage 1: magnitudes and sign
   always_comb begin
      am1_in = a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
      bm1_in = b[VAL_W-1] ? VAL_W'(-b) : VAL_W'(b);
   end

   // stage 3: combine partial products, truncate, apply sign into addend
   always_comb begin
      sum3 = {hh2_ff, {VAL_W{1'b0}}}
           + ((2*VAL_W)'(lh2_ff) << HALF_W)
           + ((2*VAL_W)'(hl2_ff) << HALF_W)
           + (2*VAL_W)'(ll2_ff);
      mag3 = sum3[FRAC_BITS +: VAL_W];
      p3_in = neg2_ff ? c2_ff - val_type'(mag3) : c2_ff + val_type'(mag3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      neg1_ff <= a[VAL_W-1] ^ b[VAL_W-1];
      am1_ff  <= am1_in;
      bm1_ff  <= bm1_in;
      c1_ff   <= c;
      // stage 2: four half-width partial products
      neg2_ff <= neg1_ff;
      c2_ff   <= c1_ff;
      ll2_ff  <= am1_ff[HALF_W-1:0] * bm1_ff[HALF_W-1:0];
      lh2_ff  <= am1_ff[HALF_W-1:0] * bm1_ff[VAL_W-1:HALF_W];
      hl2_ff  <= am1_ff[VAL_W-1:HALF_W] * bm1_ff[HALF_W-1:0];
      hh2_ff  <= am1_ff[VAL_W-1:HALF_W] * bm1_ff[VAL_W-1:HALF_W];
      p3_ff   <= p3_in;
   end

   assign out_valid = v3_ff;
   assign p         = p3_ff;

endmodule

>>> rtl/sct_reduce.sv
// two stage range reduction of the angle into [-pi, pi] in q40
module sct_reduce
   import sct_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic signed [ANGLE_W-1:0] angle,
   output logic                      out_valid,
   output val_type                   x
);

   logic    v1_ff, v2_ff;
   val_type x1_ff, x1_in, x2_ff, x2_in, xw;

   always_comb begin
      xw = val_type'(angle) <<< IN_SHIFT;
      priority if (xw >= TWO_PI_Q40)  x1_in = xw - TWO_PI_Q40;
      else if (xw <= -TWO_PI_Q40)     x1_in = xw + TWO_PI_Q40;
      else                            x1_in = xw;
   end

   always_comb begin
      priority if (x1_ff > PI_Q40)    x2_in = x1_ff - TWO_PI_Q40;
      else if (x1_ff < -PI_Q40)       x2_in = x1_ff + TWO_PI_Q40;
      else                            x2_in = x1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff <= x1_in;
      x2_ff <= x2_in;
   end

   assign out_valid = v2_ff;
   assign x         = x2_ff;

endmodule

>>> rtl/sct_step.sv
// one horner step for both series, with x and x squared carried alongside
module sct_step
   import sct_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  val_type s_in,
   input  val_type c_in,
   input  val_type x_in,
   input  val_type x2_in,
   input  val_type coeff_s,
   input  val_type coeff_c,
   output logic    out_valid,
   output val_type s_out,
   output val_type c_out,
   output val_type x_out,
   output val_type x2_out
);

   logic    unused_c_valid;
   val_type xd_ff [3];
   val_type x2d_ff [3];

   sct_mul u_mul_s (
      .clock, .reset, .in_valid,
      .a(s_in), .b(x2_in), .c(coeff_s),
      .out_valid, .p(s_out)
   );

   sct_mul u_mul_c (
      .clock, .reset, .in_valid,
      .a(c_in), .b(x2_in), .c(coeff_c),
      .out_valid(unused_c_valid), .p(c_out)
   );

   always_ff @(posedge clock) begin
      xd_ff[0]  <= x_in;
      xd_ff[1]  <= xd_ff[0];
      xd_ff[2]  <= xd_ff[1];
      x2d_ff[0] <= x2_in;
      x2d_ff[1] <= x2d_ff[0];
      x2d_ff[2] <= x2d_ff[1];
   end

   assign x_out  = unused_c_valid ? xd_ff[2] : xd_ff[2];
   assign x2_out = x2d_ff[2];

endmodule

>>> rtl/sine_cosine_taylor.sv
// top level of the pipelined taylor series sine and cosine unit
// Takes one Q4.28 angle in radians per cycle and returns its sine and cosine
// in Q2.30, saturated to plus or minus one. The unit is a fixed pipeline of
// 3*SERIES_TERMS+6 register stages (36 at ten terms): two for range
// reduction, three per multiply for x squared, for each of the
// SERIES_TERMS-1 horner steps and for the final product with x, plus the
// output register. busy is never raised, so a new item may start on every
// clock, and results come out on rsp_valid in the order the items started;
// the receiver has no way to hold results off.
`include "sine_cosine_taylor_assert.svh"

module sine_cosine_taylor
   import sct_pkg::*;
#(
   parameter int SERIES_TERMS = DEF_TERMS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [ANGLE_W-1:0] req_angle,
   output logic                      rsp_valid,
   output logic signed [RES_W-1:0]   rsp_sine,
   output logic signed [RES_W-1:0]   rsp_cosine
);

   localparam int LATENCY = 3 * SERIES_TERMS + 6;

   // leading coefficients of both series, the top of horner
   localparam val_type S_TOP = coeff_q40(2 * (SERIES_TERMS - 1) + 1, SERIES_TERMS - 1);
   localparam val_type C_TOP = coeff_q40(2 * (SERIES_TERMS - 1), SERIES_TERMS - 1);

   logic    red_valid;
   val_type red_x;
   val_type xd_ff [3];

   // horner chain, index j is the state entering step j
   logic    hv  [SERIES_TERMS];
   val_type hs  [SERIES_TERMS];
   val_type hc  [SERIES_TERMS];
   val_type hx  [SERIES_TERMS];
   val_type hx2 [SERIES_TERMS-1];

   logic    fin_valid;
   val_type fin_s;
   val_type cd_ff [3];

   logic                   out_valid_ff;
   logic signed [RES_W-1:0] sine_ff, cosine_ff, sine_in, cosine_in;

   // no backpressure anywhere: an item enters on every start
   assign busy = 1'b0;

   // range reduction into [-pi, pi]
   sct_reduce u_reduce (
      .clock, .reset,
      .in_valid(start && !busy),
      .angle(req_angle),
      .out_valid(red_valid),
      .x(red_x)
   );

   // x squared, with x delayed alongside
   sct_mul u_sq (
      .clock, .reset,
      .in_valid(red_valid),
      .a(red_x), .b(red_x), .c('0),
      .out_valid(hv[0]),
      .p(hx2[0])
   );

   always_ff @(posedge clock) begin
      xd_ff[0] <= red_x;
      xd_ff[1] <= xd_ff[0];
      xd_ff[2] <= xd_ff[1];
   end

   assign hs[0] = S_TOP;
   assign hc[0] = C_TOP;
   assign hx[0] = xd_ff[2];

   // one step per remaining term, k counts down from SERIES_TERMS-2 to 0
   for (genvar j = 0; j < SERIES_TERMS - 1; j++) begin : g_step
      localparam int K = SERIES_TERMS - 2 - j;
      if (j < SERIES_TERMS - 2) begin : g_mid
         sct_step u_step (
            .clock, .reset,
            .in_valid(hv[j]),
            .s_in(hs[j]), .c_in(hc[j]), .x_in(hx[j]), .x2_in(hx2[j]),
            .coeff_s(coeff_q40(2 * K + 1, K)),
            .coeff_c(coeff_q40(2 * K, K)),
            .out_valid(hv[j+1]),
            .s_out(hs[j+1]), .c_out(hc[j+1]), .x_out(hx[j+1]),
            .x2_out(hx2[j+1])
         );
      end else begin : g_last
         // x squared is not needed past the last step
         sct_step u_step (
            .clock, .reset,
            .in_valid(hv[j]),
            .s_in(hs[j]), .c_in(hc[j]), .x_in(hx[j]), .x2_in(hx2[j]),
            .coeff_s(coeff_q40(2 * K + 1, K)),
            .coeff_c(coeff_q40(2 * K, K)),
            .out_valid(hv[j+1]),
            .s_out(hs[j+1]), .c_out(hc[j+1]), .x_out(hx[j+1]),
            .x2_out()
         );
      end
   end

   // sine series times x, cosine waits alongside
   sct_mul u_fin (
      .clock, .reset,
      .in_valid(hv[SERIES_TERMS-1]),
      .a(hs[SERIES_TERMS-1]), .b(hx[SERIES_TERMS-1]), .c('0),
      .out_valid(fin_valid),
      .p(fin_s)
   );

   always_ff @(posedge clock) begin
      cd_ff[0] <= hc[SERIES_TERMS-1];
      cd_ff[1] <= cd_ff[0];
      cd_ff[2] <= cd_ff[1];
   end

   // q40 to q30 with truncation toward zero and saturation to one
   function automatic logic signed [RES_W-1:0] to_q30(input val_type v);
      val_type                       mv;
      logic [VAL_W-OUT_SHIFT-1:0]    mag;
      logic [RES_W-1:0]              m32;
      mv  = v[VAL_W-1] ? -v : v;
      mag = mv[VAL_W-1:OUT_SHIFT];
      if (mag > ONE_Q30) mag = ONE_Q30;
      m32 = mag[RES_W-1:0];
      return v[VAL_W-1] ? -$signed(m32) : $signed(m32);
   endfunction

   always_comb begin
      sine_in   = to_q30(fin_s);
      cosine_in = to_q30(cd_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= fin_valid;
      end
   end

   always_ff @(posedge clock) begin
      sine_ff   <= sine_in;
      cosine_ff <= cosine_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_sine   = sine_ff;
   assign rsp_cosine = cosine_ff;

   // every result traces back to an earlier start through the whole pipeline
   `SCT_ASSERT_IMP(a_latency, clock, reset, rsp_valid, $past(start, LATENCY))
   // saturation keeps both results within plus or minus one
   `SCT_ASSERT_IMP(a_sine_range, clock, reset, rsp_valid,
      (rsp_sine <= 32'sd1073741824) && (rsp_sine >= -32'sd1073741824))
   `SCT_ASSERT_IMP(a_cosine_range, clock, reset, rsp_valid,
      (rsp_cosine <= 32'sd1073741824) && (rsp_cosine >= -32'sd1073741824))
   `SCT_ASSERT_NEVER(a_no_busy, clock, reset, busy)

endmodule
